// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion helpers: implication checks with clock and reset built in
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/thhe_pkg.sv =====
//------------------------------------------------------------------------------
// thhe_pkg
// Shared types, constants and CORDIC angle table for the hump height estimator.
//------------------------------------------------------------------------------
`default_nettype none
package thhe_pkg;
    localparam int unsigned CordicSteps = 20;
    localparam logic [13:0] TiltMax     = 14'd11520;
    localparam logic [15:0] HeightMax   = 16'hFFFF;
    localparam logic [13:0] ThreshReset = 14'd1280;
    localparam int unsigned QueueDepth  = 2;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic        [15:0] range_distance;
    } t_in_item;

    typedef struct packed {
        logic [13:0] tilt_angle;
        logic        in_hump;
        logic        height_ready;
        logic [15:0] est_height;
    } t_out_item;

    // Classified item passed from front to back
    typedef struct packed {
        logic [13:0] tilt;
        logic [15:0] distance;
    } t_mid_item;

    // atan(2^-i) in degrees * 65536
    function automatic logic [21:0] atan_lut(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            default: v = 22'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/tilt_hump_height_estimator.sv =====
// Path: square root of y^2+z^2, vectoring CORDIC, then the queue hop to the
// back end; the CORDIC is skipped when x is zero or y and z are both zero.
// A sample that ends a hump can also run a rotation CORDIC, a multiply and a divide.
// The front end takes no new sample until it has handed the last one on.
// Reset: synchronous active-low; threshold returns to 1280, hump state clears.
//------------------------------------------------------------------------------
// tilt_hump_height_estimator
// Tilt angle and hump height estimator top level.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tilt_hump_height_estimator #(
    parameter int unsigned P_QUEUE_DEPTH = thhe_pkg::QueueDepth
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  thhe_pkg::t_in_item   i_item,
    output logic                 empty,
    input  wire                  pop,
    output thhe_pkg::t_out_item  o_item,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [13:0]           i_cfg_data
);
    import thhe_pkg::*;

    logic [13:0] r_thresh;
    logic        w_fv, w_fr, w_bv, w_br;
    t_mid_item   w_fi, w_bi;

    // threshold register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= ThreshReset;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    thhe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(i_item), .o_valid(w_fv), .i_ready(w_fr), .o_item(w_fi)
    );

    thhe_queue #(.DEPTH(P_QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_ready(w_fr),
        .i_item(w_fi), .o_valid(w_bv), .i_ready(w_br), .o_item(w_bi)
    );

    thhe_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_bv), .o_ready(w_br),
        .i_item(w_bi), .i_thresh(r_thresh), .o_empty(empty), .i_pop(pop),
        .o_item(o_item)
    );

    // checks
    `ASSERT_IMPL(a_tilt_range, i_clk, i_rst_n, !empty, o_item.tilt_angle <= TiltMax)
    `ASSERT_IMPL(a_ready_ends, i_clk, i_rst_n, !empty && o_item.height_ready, !o_item.in_hump)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, push && !full, full)
endmodule
`default_nettype wire

// ===== hdl/thhe_front.sv =====
//------------------------------------------------------------------------------
// thhe_front
// Tilt front end: square-root of y^2+z^2 one bit a cycle, then vectoring
// CORDIC, one step a cycle. Emits tilt and distance into the queue.
//------------------------------------------------------------------------------
`default_nettype none
module thhe_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    output logic                  o_full,
    input  thhe_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  wire                   i_ready,
    output thhe_pkg::t_mid_item   o_item
);
    import thhe_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SQRT, S_CORD, S_DONE} t_state;

    t_state             r_state;
    logic [4:0]         r_cnt;
    logic [32:0]        r_rem;     // square-root remainder
    logic [31:0]        r_n;       // radicand, shifted out two bits a step
    logic [16:0]        r_root;
    logic [15:0]        r_ax;
    logic [15:0]        r_dist;
    logic signed [34:0] r_px, r_py;
    logic signed [24:0] r_pz;
    logic [13:0]        r_tilt;

    // combinational step logic
    logic [32:0]        w_trial;
    logic [32:0]        w_rem_sh;
    logic signed [24:0] w_pzc;
    logic [15:0]        w_tr;
    logic signed [31:0] w_yy, w_zz;
    logic [31:0]        w_sq;
    logic [4:0]         w_i;
    logic signed [34:0] w_dx, w_dy;
    logic signed [24:0] w_a;

    always_comb begin
        w_rem_sh = {r_rem[30:0], r_n[31:30]};
        w_trial  = {14'd0, r_root[16:0], 2'b01};
        w_pzc    = r_pz;
        if (r_pz < 0) w_pzc = '0;
        if (r_pz > 25'sd5898240) w_pzc = 25'sd5898240;
        w_tr     = 16'((w_pzc + 25'sd256) >>> 9);
        w_yy     = i_item.accel_y * i_item.accel_y;
        w_zz     = i_item.accel_z * i_item.accel_z;
        w_sq     = unsigned'(w_yy) + unsigned'(w_zz);
        // CORDIC step datapath (shift index offset by one)
        w_i      = r_cnt - 5'd1;
        w_dx     = r_px >>> w_i;
        w_dy     = r_py >>> w_i;
        w_a      = signed'({3'd0, atan_lut(w_i)});
    end

    assign o_full  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_item  = '{tilt: r_tilt, distance: r_dist};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_ax   <= i_item.accel_x[15] ? 16'(-i_item.accel_x)
                                                     : 16'(i_item.accel_x);
                        r_dist <= i_item.range_distance;
                        r_n    <= w_sq;
                        r_rem  <= '0;
                        r_root <= '0;
                        r_cnt  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_rem_sh >= w_trial) begin
                        r_rem  <= w_rem_sh - w_trial;
                        r_root <= {r_root[15:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem_sh;
                        r_root <= {r_root[15:0], 1'b0};
                    end
                    r_n <= {r_n[29:0], 2'b00};
                    if (r_cnt == 5'd15) begin
                        r_cnt   <= '0;
                        r_state <= S_CORD;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_CORD: begin
                    if (r_cnt == 5'd0) begin
                        // load vector on first cycle
                        r_px  <= signed'({4'd0, r_root[16:0], 14'd0});
                        r_py  <= signed'({5'd0, r_ax, 14'd0});
                        r_pz  <= '0;
                        r_cnt <= 5'd1;
                        if (r_ax == 16'd0) begin
                            r_tilt <= '0; r_state <= S_DONE;
                        end else if (r_root == 17'd0) begin
                            r_tilt <= TiltMax; r_state <= S_DONE;
                        end
                    end else begin
                        // step index is r_cnt-1; counters shift by one
                        r_cnt <= r_cnt + 5'd1;
                        if (r_cnt == 5'd21) begin
                            r_tilt  <= (w_tr > 16'(TiltMax)) ? TiltMax : w_tr[13:0];
                            r_state <= S_DONE;
                        end else if (r_py >= 0) begin
                            r_px <= r_px + w_dy;
                            r_py <= r_py - w_dx;
                            r_pz <= r_pz + w_a;
                        end else begin
                            r_px <= r_px - w_dy;
                            r_py <= r_py + w_dx;
                            r_pz <= r_pz - w_a;
                        end
                    end
                end
                S_DONE: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/thhe_queue.sv =====
//------------------------------------------------------------------------------
// thhe_queue
// Small FIFO decoupling the tilt front end from the hump back end.
//------------------------------------------------------------------------------
`default_nettype none
module thhe_queue #(
    parameter int unsigned DEPTH = thhe_pkg::QueueDepth
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  thhe_pkg::t_mid_item  i_item,
    output logic                 o_valid,
    input  wire                  i_ready,
    output thhe_pkg::t_mid_item  o_item
);
    import thhe_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_mid_item      r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           w_wr, w_rd;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (w_rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/thhe_back.sv =====
//------------------------------------------------------------------------------
// thhe_back
// Hump tracker: threshold compare, peak tracking, and on hump end a rotation
// CORDIC for tan, a 32x16 multiply and a restoring divide, one step a cycle.
//------------------------------------------------------------------------------
`default_nettype none
module thhe_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  thhe_pkg::t_mid_item  i_item,
    input  wire [13:0]           i_thresh,
    output logic                 o_empty,
    input  wire                  i_pop,
    output thhe_pkg::t_out_item  o_item
);
    import thhe_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CORD, S_MUL, S_DIV, S_OUT} t_state;

    t_state             r_state;
    logic               r_active;
    logic [15:0]        r_start;
    logic [13:0]        r_peak;
    logic [15:0]        r_height;
    logic [13:0]        r_tilt;
    logic               r_ready_flag;
    logic [4:0]         r_cnt;
    logic [15:0]        r_d;
    logic signed [33:0] r_px, r_py;
    logic signed [24:0] r_pz;
    logic [48:0]        r_num;     // D*S + C
    logic [31:0]        r_den;     // 2*C, below 2^32
    logic [48:0]        r_rem;
    logic [16:0]        r_q;       // quotient bits above 16 mean saturate
    logic [5:0]         r_dcnt;

    logic [13:0]        w_peak_n;
    logic [15:0]        w_dist_d;
    logic signed [33:0] w_dx, w_dy;
    logic signed [24:0] w_a;
    logic [49:0]        w_rsh;
    logic [31:0]        w_s;
    logic [47:0]        w_prod;
    logic               w_qbit;
    logic [16:0]        w_q_n;

    assign w_peak_n = (i_item.tilt > r_peak) ? i_item.tilt : r_peak;
    assign w_dist_d = (i_item.distance >= r_start) ? i_item.distance - r_start
                                                   : r_start - i_item.distance;
    assign w_dx = r_px >>> r_cnt;
    assign w_dy = r_py >>> r_cnt;
    assign w_a  = signed'({3'd0, atan_lut(r_cnt)});
    assign w_rsh = {r_rem, r_num[48]};

    // sine side, negative taken as zero, times distance moved
    assign w_s    = (r_py < 0) ? 32'd0 : r_py[31:0];
    assign w_prod = r_d * w_s;

    // next quotient bit, saturating once past 16 bits
    assign w_qbit = (w_rsh >= 50'(r_den));
    assign w_q_n  = (r_q[16:15] == 2'b00) ? {r_q[15:0], w_qbit} : 17'h1FFFF;

    assign o_ready = (r_state == S_IDLE);
    assign o_empty = (r_state != S_OUT);
    assign o_item  = '{tilt_angle: r_tilt, in_hump: r_active,
                       height_ready: r_ready_flag, est_height: r_height};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_start  <= '0;
            r_peak   <= '0;
            r_height <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tilt       <= i_item.tilt;
                        r_ready_flag <= 1'b0;
                        r_state      <= S_OUT;
                        if (!r_active) begin
                            if (i_item.tilt >= i_thresh) begin
                                r_active <= 1'b1;
                                r_start  <= i_item.distance;
                            end
                        end else if (i_item.tilt < i_thresh) begin
                            r_active     <= 1'b0;
                            r_peak       <= '0;
                            r_ready_flag <= 1'b1;
                            if (w_dist_d == 16'd0 || w_peak_n == 14'd0) begin
                                r_height <= '0;
                            end else if (w_peak_n >= TiltMax) begin
                                r_height <= HeightMax;
                            end else begin
                                r_d     <= w_dist_d;
                                r_px    <= 34'sd1 <<< 30;
                                r_py    <= '0;
                                r_pz    <= signed'({2'd0, w_peak_n, 9'd0});
                                r_cnt   <= '0;
                                r_state <= S_CORD;
                            end
                        end else begin
                            r_peak <= w_peak_n;
                        end
                    end
                end
                S_CORD: begin
                    if (r_pz >= 0) begin
                        r_px <= r_px - w_dy;
                        r_py <= r_py + w_dx;
                        r_pz <= r_pz - w_a;
                    end else begin
                        r_px <= r_px + w_dy;
                        r_py <= r_py - w_dx;
                        r_pz <= r_pz + w_a;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(CordicSteps-1)) r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_px <= 0) begin
                        r_height <= HeightMax;
                        r_state  <= S_OUT;
                    end else begin
                        r_num  <= {1'b0, w_prod} + {17'd0, r_px[31:0]};
                        r_den  <= {r_px[30:0], 1'b0};
                        r_rem  <= '0;
                        r_q    <= '0;
                        r_dcnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    r_rem  <= w_qbit ? 49'(w_rsh - 50'(r_den)) : w_rsh[48:0];
                    r_q    <= w_q_n;
                    r_num  <= {r_num[47:0], 1'b0};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd48) begin
                        r_height <= w_q_n[16] ? HeightMax : w_q_n[15:0];
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_pop) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
